### rtl/core/dfsp_pkg.sv
package dfsp_pkg;

    // Defaults for the top-level parameters
    localparam int NUM_BINS_DEF     = 64;
    localparam int COUNTER_BITS_DEF = 32;

    // Job queue between parser and output sequencer
    localparam int QUEUE_DEPTH = 4;

    // Stream widths
    localparam int S_TDATA_W  = 48;
    localparam int M_FIELDS_W = 126;
    localparam int M_TDATA_W  = 128;
    localparam int BIN_W      = 16;

    // Sync words
    localparam logic [7:0] LVL_SYNC1  = 8'hAA;
    localparam logic [7:0] LVL_SYNC2  = 8'h55;
    localparam logic [7:0] SPEC_SYNC1 = 8'hDD;
    localparam logic [7:0] SPEC_SYNC2 = 8'h77;

    // Byte positions inside a frame
    localparam logic [2:0] BODY_START   = 3'd2;
    localparam logic [2:0] SPEC_CHK_POS = 3'd5;
    localparam logic [2:0] LVL_CHK_POS  = 3'd7;

    // Forward sequence distances below this count as drops
    localparam logic [7:0] SEQ_HALF = 8'd128;

    // Result kind, also used as job kind (bin kind = full bin run)
    typedef enum logic [1:0] {
        KIND_LEVEL = 2'd0,
        KIND_BIN   = 2'd1,
        KIND_READ  = 2'd2
    } kind_t;

    // Statistics counter selects
    typedef enum logic [2:0] {
        SEL_VALID   = 3'd0,
        SEL_CHKFAIL = 3'd1,
        SEL_SYNCRST = 3'd2,
        SEL_DROP    = 3'd3,
        SEL_REORDER = 3'd4,
        SEL_MAXGAP  = 3'd5,
        SEL_LASTSEQ = 3'd6
    } sel_t;

    // One queued job; fields unused by the kind are zero
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  frame_result;
        logic [7:0]  rms_level;
        logic [7:0]  frame_flags;
        logic [7:0]  sequence_res;
        logic [7:0]  metric_value;
        logic [31:0] receive_time;
        logic [31:0] counter_value;
    } job_t;

    // Bin store write from the parser
    typedef struct packed {
        logic        en;
        logic [7:0]  addr;
        logic [15:0] data;
    } bin_wr_t;

endpackage

### rtl/core/dual_frame_sync_parser.sv
// Serial frame parser with statistics. Each input beat (tuser = command) is
// either a received byte with its millisecond stamp or a counter read; the
// parser takes one beat per clock unless held off and hands jobs through a
// four-entry queue to an output sequencer, so either side may stall on its
// own. A level frame or a counter read gives one result beat (tuser = kind,
// tlast set), offered once the job has been registered in the queue and then
// loaded into the sequencer's output register. A valid spectrum frame for the
// top bin gives NUM_BINS beats, one per clock while ready is high, read in
// turn from the bin memory. The sequencer returns to idle between jobs. The
// input is held off while the queue is full, and the check byte of a spectrum
// frame is held off while an earlier bin run is still queued or being sent.
// The bin memory needs no clearing pass: per-bin valid bits make unwritten
// bins read as zero straight after reset.
module dual_frame_sync_parser #(
    parameter int NUM_BINS     = dfsp_pkg::NUM_BINS_DEF,
    parameter int COUNTER_BITS = dfsp_pkg::COUNTER_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // rx_byte[7:0], time_ms[39:8], counter_select[42:40], zero pad
    input  logic [dfsp_pkg::S_TDATA_W-1:0] s_tdata,
    // command[0]
    input  logic [0:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // frame_result[7:0], rms_level[15:8], frame_flags[23:16],
    // sequence_res[31:24], metric_value[39:32], receive_time[71:40],
    // bin_number[77:72], bin_value[93:78], counter_value[125:94], zero pad
    output logic [dfsp_pkg::M_TDATA_W-1:0] m_tdata,
    // kind[1:0]
    output logic [1:0]                     m_tuser,
    output logic                           m_tlast
);
    import dfsp_pkg::*;

    logic    q_push;
    job_t    q_in_job;
    logic    q_full;
    logic    q_pop;
    job_t    q_out_job;
    logic    q_empty;
    bin_wr_t bin_wr;
    logic    dump_done;

    // Parser and statistics
    dfsp_front #(
        .NUM_BINS     (NUM_BINS),
        .COUNTER_BITS (COUNTER_BITS)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .command        (s_tuser[0]),
        .rx_byte        (s_tdata[7:0]),
        .time_ms        (s_tdata[39:8]),
        .counter_select (s_tdata[42:40]),
        .q_push         (q_push),
        .q_job          (q_in_job),
        .q_full         (q_full),
        .bin_wr         (bin_wr),
        .dump_done      (dump_done)
    );

    // Job queue
    dfsp_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (q_in_job),
        .full     (q_full),
        .pop      (q_pop),
        .pop_job  (q_out_job),
        .empty    (q_empty)
    );

    // Output sequencer with bin memory
    dfsp_back #(
        .NUM_BINS (NUM_BINS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_empty   (q_empty),
        .q_job     (q_out_job),
        .q_pop     (q_pop),
        .bin_wr    (bin_wr),
        .dump_done (dump_done),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

### rtl/core/dfsp_ram.sv
module dfsp_ram #(
    parameter int WIDTH = dfsp_pkg::BIN_W,
    parameter int DEPTH = dfsp_pkg::NUM_BINS_DEF
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/core/dfsp_front.sv
module dfsp_front #(
    parameter int NUM_BINS     = dfsp_pkg::NUM_BINS_DEF,
    parameter int COUNTER_BITS = dfsp_pkg::COUNTER_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic              command,
    input  logic [7:0]        rx_byte,
    input  logic [31:0]       time_ms,
    input  logic [2:0]        counter_select,
    output logic              q_push,
    output dfsp_pkg::job_t    q_job,
    input  logic              q_full,
    output dfsp_pkg::bin_wr_t bin_wr,
    input  logic              dump_done
);
    import dfsp_pkg::*;

    localparam int         CB        = COUNTER_BITS;
    localparam int         DCW       = $clog2(QUEUE_DEPTH + 2);
    localparam logic [8:0] BIN_LIMIT = 9'(NUM_BINS);
    localparam logic [7:0] BIN_LAST  = 8'(NUM_BINS - 1);

    typedef enum logic [2:0] {
        PH_SYNC1,
        PH_SYNC2_LVL,
        PH_SYNC2_SPEC,
        PH_LVL_BODY,
        PH_SPEC_BODY
    } phase_t;

    phase_t          phase_reg, phase_next;
    logic [2:0]      pos_reg, pos_next;
    logic            seen_reg, seen_next;
    logic [7:0]      prev_seq_reg, prev_seq_next;
    logic [31:0]     last_time_reg, last_time_next;
    logic [CB-1:0]   valid_cnt_reg, valid_cnt_next;
    logic [CB-1:0]   chk_cnt_reg, chk_cnt_next;
    logic [CB-1:0]   sync_cnt_reg, sync_cnt_next;
    logic [CB-1:0]   drop_cnt_reg, drop_cnt_next;
    logic [CB-1:0]   reord_cnt_reg, reord_cnt_next;
    logic [CB-1:0]   max_gap_reg, max_gap_next;
    logic [DCW-1:0]  dump_cnt_reg, dump_cnt_next;

    // Body bytes shift in at the top; taps read at fixed places
    logic [7:0]      fb_reg [5];
    logic            fb_shift;

    logic            accept;
    logic            bin_stall;
    logic            dump_push;
    logic [7:0]      lvl_x;
    logic [7:0]      spec_x;
    logic [31:0]     gap32;
    logic [CB-1:0]   gap;
    logic [7:0]      seq_expect;
    logic [7:0]      seq_ahead;

    // Hold the byte that would write the bin store while a bin run is still owed
    assign bin_stall = (phase_reg == PH_SPEC_BODY) && (pos_reg == SPEC_CHK_POS)
                       && (dump_cnt_reg != '0);
    assign s_tready  = !q_full && !bin_stall;
    assign accept    = s_tvalid && s_tready;

    // Check terms, gap and sequence distance
    assign lvl_x      = fb_reg[0] ^ fb_reg[1] ^ fb_reg[2] ^ fb_reg[3] ^ fb_reg[4]
                        ^ LVL_SYNC1 ^ LVL_SYNC2;
    assign spec_x     = fb_reg[2] ^ fb_reg[3] ^ fb_reg[4] ^ SPEC_SYNC1 ^ SPEC_SYNC2;
    assign gap32      = time_ms - last_time_reg;
    assign gap        = CB'(gap32);
    assign seq_expect = prev_seq_reg + 8'd1;
    assign seq_ahead  = fb_reg[3] - seq_expect;

    // Parser and statistics
    always_comb begin
        phase_next     = phase_reg;
        pos_next       = pos_reg;
        seen_next      = seen_reg;
        prev_seq_next  = prev_seq_reg;
        last_time_next = last_time_reg;
        valid_cnt_next = valid_cnt_reg;
        chk_cnt_next   = chk_cnt_reg;
        sync_cnt_next  = sync_cnt_reg;
        drop_cnt_next  = drop_cnt_reg;
        reord_cnt_next = reord_cnt_reg;
        max_gap_next   = max_gap_reg;
        q_push         = 1'b0;
        q_job          = '0;
        bin_wr         = '0;
        dump_push      = 1'b0;
        fb_shift       = 1'b0;

        if (accept) begin
            if (command) begin
                q_push     = 1'b1;
                q_job.kind = KIND_READ;
                case (counter_select)
                    SEL_VALID:   q_job.counter_value = 32'(valid_cnt_reg);
                    SEL_CHKFAIL: q_job.counter_value = 32'(chk_cnt_reg);
                    SEL_SYNCRST: q_job.counter_value = 32'(sync_cnt_reg);
                    SEL_DROP:    q_job.counter_value = 32'(drop_cnt_reg);
                    SEL_REORDER: q_job.counter_value = 32'(reord_cnt_reg);
                    SEL_MAXGAP: begin
                        q_job.counter_value = 32'(max_gap_reg);
                        max_gap_next        = '0;
                    end
                    SEL_LASTSEQ: q_job.counter_value = 32'(prev_seq_reg);
                    default:     q_job.counter_value = '0;
                endcase
            end else begin
                case (phase_reg)
                    PH_SYNC1: begin
                        if (rx_byte == LVL_SYNC1) begin
                            phase_next = PH_SYNC2_LVL;
                        end else if (rx_byte == SPEC_SYNC1) begin
                            phase_next = PH_SYNC2_SPEC;
                        end
                    end
                    PH_SYNC2_LVL: begin
                        if (rx_byte == LVL_SYNC2) begin
                            phase_next = PH_LVL_BODY;
                            pos_next   = BODY_START;
                        end else if (rx_byte != LVL_SYNC1) begin
                            sync_cnt_next = sync_cnt_reg + CB'(1);
                            phase_next    = PH_SYNC1;
                        end
                    end
                    PH_SYNC2_SPEC: begin
                        if (rx_byte == SPEC_SYNC2) begin
                            phase_next = PH_SPEC_BODY;
                            pos_next   = BODY_START;
                        end else if (rx_byte != SPEC_SYNC1) begin
                            sync_cnt_next = sync_cnt_reg + CB'(1);
                            phase_next    = PH_SYNC1;
                        end
                    end
                    PH_LVL_BODY: begin
                        if (pos_reg == LVL_CHK_POS) begin
                            phase_next = PH_SYNC1;
                            if (lvl_x != rx_byte) begin
                                chk_cnt_next = chk_cnt_reg + CB'(1);
                            end else begin
                                valid_cnt_next = valid_cnt_reg + CB'(1);
                                // zero time stamp means no earlier frame
                                if ((last_time_reg != '0) && (gap > max_gap_reg)) begin
                                    max_gap_next = gap;
                                end
                                last_time_next = time_ms;
                                // first frame only records its sequence
                                if (!seen_reg) begin
                                    seen_next = 1'b1;
                                end else if (fb_reg[3] != seq_expect) begin
                                    if (seq_ahead < SEQ_HALF) begin
                                        drop_cnt_next = drop_cnt_reg + CB'(seq_ahead);
                                    end else begin
                                        reord_cnt_next = reord_cnt_reg + CB'(1);
                                    end
                                end
                                prev_seq_next      = fb_reg[3];
                                q_push             = 1'b1;
                                q_job.kind         = KIND_LEVEL;
                                q_job.frame_result = fb_reg[0];
                                q_job.rms_level    = fb_reg[1];
                                q_job.frame_flags  = fb_reg[2];
                                q_job.sequence_res = fb_reg[3];
                                q_job.metric_value = fb_reg[4];
                                q_job.receive_time = time_ms;
                            end
                        end else begin
                            fb_shift = 1'b1;
                            pos_next = pos_reg + 3'd1;
                        end
                    end
                    PH_SPEC_BODY: begin
                        if (pos_reg == SPEC_CHK_POS) begin
                            phase_next = PH_SYNC1;
                            if (spec_x != rx_byte) begin
                                chk_cnt_next = chk_cnt_reg + CB'(1);
                            end else if ({1'b0, fb_reg[2]} < BIN_LIMIT) begin
                                bin_wr.en   = 1'b1;
                                bin_wr.addr = fb_reg[2];
                                bin_wr.data = {fb_reg[4], fb_reg[3]};
                                // top bin sends the whole store
                                if (fb_reg[2] == BIN_LAST) begin
                                    q_push     = 1'b1;
                                    q_job.kind = KIND_BIN;
                                    dump_push  = 1'b1;
                                end
                            end
                        end else begin
                            fb_shift = 1'b1;
                            pos_next = pos_reg + 3'd1;
                        end
                    end
                    default: phase_next = PH_SYNC1;
                endcase
            end
        end

        dump_cnt_next = dump_cnt_reg + DCW'(dump_push) - DCW'(dump_done);
    end

    // State and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_SYNC1;
            pos_reg       <= '0;
            seen_reg      <= 1'b0;
            prev_seq_reg  <= '0;
            last_time_reg <= '0;
            valid_cnt_reg <= '0;
            chk_cnt_reg   <= '0;
            sync_cnt_reg  <= '0;
            drop_cnt_reg  <= '0;
            reord_cnt_reg <= '0;
            max_gap_reg   <= '0;
            dump_cnt_reg  <= '0;
        end else begin
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            seen_reg      <= seen_next;
            prev_seq_reg  <= prev_seq_next;
            last_time_reg <= last_time_next;
            valid_cnt_reg <= valid_cnt_next;
            chk_cnt_reg   <= chk_cnt_next;
            sync_cnt_reg  <= sync_cnt_next;
            drop_cnt_reg  <= drop_cnt_next;
            reord_cnt_reg <= reord_cnt_next;
            max_gap_reg   <= max_gap_next;
            dump_cnt_reg  <= dump_cnt_next;
        end
    end

    // Frame body shift line
    always_ff @(posedge aclk) begin
        if (fb_shift) begin
            for (int i = 0; i < 4; i++) begin
                fb_reg[i] <= fb_reg[i + 1];
            end
            fb_reg[4] <= rx_byte;
        end
    end

    // Bin store must never change under a pending or running bin run
    assert property (@(posedge aclk) disable iff (!aresetn)
        bin_wr.en |-> (dump_cnt_reg == '0))
        else $error("bin write while a bin run is outstanding");

    assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_full)
        else $error("job pushed into a full queue");

    assert property (@(posedge aclk) disable iff (!aresetn)
        dump_done |-> (dump_cnt_reg != '0))
        else $error("bin run finished with none outstanding");

endmodule

### rtl/core/dfsp_queue.sv
module dfsp_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  dfsp_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output dfsp_pkg::job_t pop_job,
    output logic           empty
);
    import dfsp_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    job_t          mem_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full    = (count_reg == CW'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_job = mem_reg[rd_ptr_reg];

    // Pointer wrap and fill level
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

### rtl/core/dfsp_back.sv
module dfsp_back #(
    parameter int NUM_BINS = dfsp_pkg::NUM_BINS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           q_empty,
    input  dfsp_pkg::job_t                 q_job,
    output logic                           q_pop,
    input  dfsp_pkg::bin_wr_t              bin_wr,
    output logic                           dump_done,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [dfsp_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [1:0]                     m_tuser,
    output logic                           m_tlast
);
    import dfsp_pkg::*;

    localparam int          AW       = $clog2(NUM_BINS);
    localparam logic [AW-1:0] LAST_IDX = AW'(NUM_BINS - 1);
    localparam int          PAD_W    = M_TDATA_W - M_FIELDS_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SINGLE,
        ST_DUMP
    } state_t;

    state_t               state_reg;
    logic                 m_tvalid_reg;
    job_t                 job_reg;
    logic [AW-1:0]        idx_reg;
    logic                 ok_reg;
    logic [NUM_BINS-1:0]  bin_valid_reg;

    logic                 re;
    logic [AW-1:0]        raddr;
    logic [BIN_W-1:0]     rdata;
    logic                 is_bin;
    logic [5:0]           bin_idx_out;
    logic [BIN_W-1:0]     bin_val_out;

    // Bin store; entries not yet written read as zero via the valid bits
    dfsp_ram #(
        .WIDTH (BIN_W),
        .DEPTH (NUM_BINS)
    ) u_bin_ram (
        .aclk  (aclk),
        .we    (bin_wr.en),
        .waddr (AW'(bin_wr.addr)),
        .wdata (bin_wr.data),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Job fetch and bin read address
    always_comb begin
        q_pop     = (state_reg == ST_IDLE) && !q_empty;
        re        = 1'b0;
        raddr     = '0;
        dump_done = 1'b0;
        if (q_pop && (q_job.kind == KIND_BIN)) begin
            re = 1'b1;
        end
        if ((state_reg == ST_DUMP) && m_tready) begin
            if (idx_reg == LAST_IDX) begin
                dump_done = 1'b1;
            end else begin
                re    = 1'b1;
                raddr = idx_reg + 1'b1;
            end
        end
    end

    // Output sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_tvalid_reg  <= 1'b0;
            bin_valid_reg <= '0;
        end else begin
            if (bin_wr.en) begin
                bin_valid_reg[AW'(bin_wr.addr)] <= 1'b1;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (q_pop) begin
                        job_reg      <= q_job;
                        idx_reg      <= '0;
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= (q_job.kind == KIND_BIN) ? ST_DUMP : ST_SINGLE;
                    end
                end
                ST_SINGLE: begin
                    if (m_tready) begin
                        m_tvalid_reg <= 1'b0;
                        state_reg    <= ST_IDLE;
                    end
                end
                ST_DUMP: begin
                    if (m_tready) begin
                        if (idx_reg == LAST_IDX) begin
                            m_tvalid_reg <= 1'b0;
                            state_reg    <= ST_IDLE;
                        end else begin
                            idx_reg <= idx_reg + 1'b1;
                        end
                    end
                end
                default: begin
                    m_tvalid_reg <= 1'b0;
                    state_reg    <= ST_IDLE;
                end
            endcase
            if (re) begin
                ok_reg <= bin_valid_reg[raddr];
            end
        end
    end

    // Beat assembly, lowest field first
    assign is_bin      = (job_reg.kind == KIND_BIN);
    assign bin_idx_out = is_bin ? 6'(idx_reg) : '0;
    assign bin_val_out = (is_bin && ok_reg) ? rdata : '0;

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = job_reg.kind;
    assign m_tlast  = !is_bin || (idx_reg == LAST_IDX);
    assign m_tdata  = {{PAD_W{1'b0}}, job_reg.counter_value, bin_val_out, bin_idx_out,
                       job_reg.receive_time, job_reg.metric_value, job_reg.sequence_res,
                       job_reg.frame_flags, job_reg.rms_level, job_reg.frame_result};

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DUMP && m_tready && idx_reg != LAST_IDX)
        |=> (idx_reg == $past(idx_reg) + 1'b1) && m_tvalid)
        else $error("bin run skipped or lost a beat");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !m_tvalid)
        else $error("beat offered with no job loaded");

    assert property (@(posedge aclk) disable iff (!aresetn)
        bin_wr.en |-> (state_reg != ST_DUMP))
        else $error("bin store written during a bin run");

endmodule
